// ===== hdl/fhd_pkg.sv =====
// shared types, request codes and deflate code tables for the fixed huffman encoder
package fhd_pkg;

    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_LIT   = 2'd1;
    localparam logic [1:0] REQ_MATCH = 2'd2;
    localparam logic [1:0] REQ_END   = 2'd3;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int ACC_W   = 38;
    localparam int CODE_W  = 31;

    typedef struct packed {
        logic [1:0]  req_type;
        logic        final_block;
        logic [7:0]  literal_byte;
        logic [8:0]  match_length;
        logic [15:0] match_distance;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       block_done;
    } out_t;

    // one token as a bit string, oldest bit in bit 0
    typedef struct packed {
        logic [CODE_W-1:0] bits;
        logic [4:0]        nbits;
        logic              eob;
    } q_entry_t;

    function automatic logic [8:0] len_base(input logic [4:0] i);
        logic [8:0] b;
        case (i)
            5'd0:  b = 9'd3;    5'd1:  b = 9'd4;    5'd2:  b = 9'd5;    5'd3:  b = 9'd6;
            5'd4:  b = 9'd7;    5'd5:  b = 9'd8;    5'd6:  b = 9'd9;    5'd7:  b = 9'd10;
            5'd8:  b = 9'd11;   5'd9:  b = 9'd13;   5'd10: b = 9'd15;   5'd11: b = 9'd17;
            5'd12: b = 9'd19;   5'd13: b = 9'd23;   5'd14: b = 9'd27;   5'd15: b = 9'd31;
            5'd16: b = 9'd35;   5'd17: b = 9'd43;   5'd18: b = 9'd51;   5'd19: b = 9'd59;
            5'd20: b = 9'd67;   5'd21: b = 9'd83;   5'd22: b = 9'd99;   5'd23: b = 9'd115;
            5'd24: b = 9'd131;  5'd25: b = 9'd163;  5'd26: b = 9'd195;  5'd27: b = 9'd227;
            default: b = 9'd258;
        endcase
        return b;
    endfunction

    function automatic logic [15:0] dist_base(input logic [4:0] i);
        logic [15:0] b;
        case (i)
            5'd0:  b = 16'd1;     5'd1:  b = 16'd2;     5'd2:  b = 16'd3;
            5'd3:  b = 16'd4;     5'd4:  b = 16'd5;     5'd5:  b = 16'd7;
            5'd6:  b = 16'd9;     5'd7:  b = 16'd13;    5'd8:  b = 16'd17;
            5'd9:  b = 16'd25;    5'd10: b = 16'd33;    5'd11: b = 16'd49;
            5'd12: b = 16'd65;    5'd13: b = 16'd97;    5'd14: b = 16'd129;
            5'd15: b = 16'd193;   5'd16: b = 16'd257;   5'd17: b = 16'd385;
            5'd18: b = 16'd513;   5'd19: b = 16'd769;   5'd20: b = 16'd1025;
            5'd21: b = 16'd1537;  5'd22: b = 16'd2049;  5'd23: b = 16'd3073;
            5'd24: b = 16'd4097;  5'd25: b = 16'd6145;  5'd26: b = 16'd8193;
            5'd27: b = 16'd12289; 5'd28: b = 16'd16385; 5'd29: b = 16'd24577;
            default: b = 16'hFFFF;
        endcase
        return b;
    endfunction

    function automatic logic [2:0] len_extra(input logic [4:0] i);
        return (i < 5'd8) ? 3'd0 : 3'(i[4:2] - 3'd1);
    endfunction

    function automatic logic [3:0] dist_extra(input logic [4:0] i);
        return (i < 5'd4) ? 4'd0 : 4'(i[4:1] - 4'd1);
    endfunction

    // huffman codes go out msb first, so flip the low n bits
    function automatic logic [8:0] rev_code(input logic [8:0] c, input logic [3:0] n);
        logic [8:0] r;
        int idx;
        r = '0;
        for (int k = 0; k < 9; k++) begin
            idx = int'(n) - 1 - k;
            if (idx >= 0)
                r[k] = c[idx];
        end
        return r;
    endfunction

endpackage

// ===== hdl/fhd_front.sv =====
// token front end: clamps, looks up fixed codes and packs each token into one bit string
module fhd_front
    import fhd_pkg::*;
#(
    parameter int MAX_MATCH_DISTANCE = 32768
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  in_t      token,
    input  logic     push,
    output logic     full,
    output logic     q_wr,
    output q_entry_t q_data,
    input  logic     q_full
);

    typedef struct packed {
        logic        is_match;
        logic        eob;
        logic [8:0]  head;
        logic [3:0]  head_len;
        logic [4:0]  lext;
        logic [2:0]  lext_len;
        logic [4:0]  dcode;
        logic [12:0] dext;
        logic [3:0]  dext_len;
    } tok_t;

    tok_t tok_reg, tok_next;
    logic valid_reg;
    logic advance;

    logic [8:0]  len_c;
    logic [15:0] dist_c;
    logic [4:0]  li, di;
    logic [8:0]  lcode;
    logic [3:0]  lcode_len;

    assign advance = !valid_reg || !q_full;
    assign full    = !advance;

    // stage one: classify and look up
    always_comb
    begin
        len_c = token.match_length;
        if (len_c < 9'd3)
            len_c = 9'd3;
        if (len_c > 9'd258)
            len_c = 9'd258;
        dist_c = token.match_distance;
        if (dist_c == 16'd0)
            dist_c = 16'd1;
        if (32'(dist_c) > 32'(MAX_MATCH_DISTANCE))
            dist_c = 16'(MAX_MATCH_DISTANCE);

        // bases ascend, so the last base not above the value wins
        li = 5'd0;
        for (int j = 1; j < 28; j++)
        begin
            if (len_c >= len_base(5'(j)))
                li = 5'(j);
        end
        di = 5'd0;
        for (int j = 1; j < 30; j++)
        begin
            if (dist_c >= dist_base(5'(j)))
                di = 5'(j);
        end

        if (len_c == 9'd258)
        begin
            lcode     = 9'h0C5;
            lcode_len = 4'd8;
        end
        else if (li <= 5'd22)
        begin
            lcode     = 9'(li) + 9'd1;
            lcode_len = 4'd7;
        end
        else
        begin
            lcode     = 9'h0C0 + 9'(li - 5'd23);
            lcode_len = 4'd8;
        end

        tok_next = '0;
        case (token.req_type)
            REQ_START:
            begin
                tok_next.head     = {7'd0, 1'b1, token.final_block};
                tok_next.head_len = 4'd3;
            end
            REQ_LIT:
            begin
                if (token.literal_byte < 8'd144)
                begin
                    tok_next.head     = rev_code(9'(token.literal_byte) + 9'h030, 4'd8);
                    tok_next.head_len = 4'd8;
                end
                else
                begin
                    tok_next.head     = rev_code(9'(token.literal_byte) + 9'h100, 4'd9);
                    tok_next.head_len = 4'd9;
                end
            end
            REQ_MATCH:
            begin
                tok_next.is_match = 1'b1;
                tok_next.head     = rev_code(lcode, lcode_len);
                tok_next.head_len = lcode_len;
                if (len_c != 9'd258)
                begin
                    tok_next.lext     = 5'(len_c - len_base(li));
                    tok_next.lext_len = len_extra(li);
                end
                tok_next.dcode    = 5'(rev_code(9'(di), 4'd5));
                tok_next.dext     = 13'(dist_c - dist_base(di));
                tok_next.dext_len = dist_extra(di);
            end
            default:
            begin
                tok_next.eob      = 1'b1;
                tok_next.head_len = 4'd7;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= push;
    end

    always_ff @(posedge clk)
    begin
        if (advance && push)
            tok_reg <= tok_next;
    end

    // stage two: splice the pieces into one lsb-first string
    logic [4:0] pos2, pos3;

    always_comb
    begin
        pos2 = 5'(tok_reg.head_len) + 5'(tok_reg.lext_len);
        pos3 = pos2 + (tok_reg.is_match ? 5'd5 : 5'd0);
        q_data.bits = CODE_W'(tok_reg.head)
                    | (CODE_W'(tok_reg.lext) << tok_reg.head_len)
                    | (CODE_W'(tok_reg.dcode) << pos2)
                    | (CODE_W'(tok_reg.dext) << pos3);
        q_data.nbits = pos3 + 5'(tok_reg.dext_len);
        q_data.eob   = tok_reg.eob;
    end

    assign q_wr = valid_reg && !q_full;

endmodule

// ===== hdl/fhd_queue.sv =====
// small fifo of packed token strings between front end and bit packer
module fhd_queue
    import fhd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr,
    input  q_entry_t wr_data,
    output logic     q_full,
    input  logic     rd,
    output logic     rd_valid,
    output q_entry_t rd_data
);

    q_entry_t          slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wptr_reg, rptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_wr, do_rd;

    assign q_full   = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = slot_reg[rptr_reg];
    assign do_wr    = wr && !q_full;
    assign do_rd    = rd && rd_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wptr_reg <= wptr_reg + 1'b1;
            if (do_rd)
                rptr_reg <= rptr_reg + 1'b1;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wptr_reg] <= wr_data;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QPTR_W+1)'(QDEPTH))
        else $error("fhd_queue: count past depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) || (count_reg == (QPTR_W+1)'(QDEPTH)) || (wptr_reg != rptr_reg))
        else $error("fhd_queue: pointers meet with partial fill");

    assert property (@(posedge clk) disable iff (!rst_n)
        do_wr && !do_rd |=> count_reg == $past(count_reg) + 1'b1)
        else $error("fhd_queue: write not counted");

endmodule

// ===== hdl/fhd_back.sv =====
// bit packer: merges token strings into the accumulator and sends one byte a cycle unless stalled
module fhd_back
    import fhd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     q_valid,
    input  q_entry_t q_data,
    output logic     q_rd,
    output out_t     result,
    output logic     empty,
    input  logic     pop
);

    logic [ACC_W-1:0] acc_reg, acc_next, acc_after;
    logic [5:0]       cnt_reg, cnt_next, cnt_after, cnt_sum;
    logic             eob_reg, eob_next;
    out_t             out_reg;
    logic             out_valid_reg;
    logic             emit, done, take;

    assign emit = (cnt_reg >= 6'd8) && (!out_valid_reg || pop);
    // a block ends on the byte that leaves fewer than eight bits behind
    assign done = eob_reg && (cnt_reg < 6'd16);
    assign acc_after = emit ? (acc_reg >> 8) : acc_reg;
    assign cnt_after = emit ? (cnt_reg - 6'd8) : cnt_reg;
    assign take = q_valid && (cnt_after < 6'd8);
    assign q_rd = take;
    assign cnt_sum = cnt_after + 6'(q_data.nbits);

    always_comb
    begin
        acc_next = acc_after;
        cnt_next = cnt_after;
        eob_next = (emit && done) ? 1'b0 : eob_reg;
        if (take)
        begin
            acc_next = acc_after | (ACC_W'(q_data.bits) << cnt_after[2:0]);
            if (q_data.eob)
            begin
                // end code then zero pad to the byte boundary
                cnt_next = (cnt_sum + 6'd7) & 6'b111000;
                eob_next = 1'b1;
            end
            else
                cnt_next = cnt_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            cnt_reg       <= '0;
            eob_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
            eob_reg <= eob_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg.out_byte   <= acc_reg[7:0];
            out_reg.block_done <= done;
        end
    end

    assign result = out_reg;
    assign empty  = !out_valid_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 6'(ACC_W))
        else $error("fhd_back: accumulator overfilled");

    assert property (@(posedge clk) disable iff (!rst_n)
        eob_reg |-> (cnt_reg[2:0] == 3'd0) && (cnt_reg != 6'd0))
        else $error("fhd_back: block end not byte aligned");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg < 6'd8) |-> !eob_reg)
        else $error("fhd_back: block end pending with no byte left");

    assert property (@(posedge clk) disable iff (!rst_n)
        take |=> cnt_reg >= 6'd1)
        else $error("fhd_back: merge lost its bits");

endmodule

// ===== hdl/fixed_huffman_deflate_encoder.sv =====
// top level of the fixed huffman deflate block encoder
//
// input channel: one lz77 token per beat on token, taken when push is high
// and full is low; req_type selects block start, literal, match or block end.
// output channel: compressed stream bytes, lsb first, on result while empty
// is low; a byte leaves when pop is high. block_done marks the last padded
// byte of each block end.
// path: a token passes the lookup register, the fifo, the merge into the
// accumulator and the output register before its first byte is on result.
// throughput: one token a cycle enters while full is low; the byte port sends
// one byte a cycle unless the receiver stalls, and the packer takes a new token
// only once fewer than eight bits are left, so the output byte rate sets the
// sustained pace.
// a four-deep token fifo lets the front end keep taking tokens while the
// packer waits on a stalled receiver; when it fills, full rises.
// reset empties the fifo and clears the bit accumulator and the output valid flag.
module fixed_huffman_deflate_encoder
    import fhd_pkg::*;
#(
    parameter int MAX_MATCH_DISTANCE = 32768
)
(
    input  logic clk,
    input  logic rst_n,
    input  in_t  token,
    input  logic push,
    output logic full,
    output out_t result,
    output logic empty,
    input  logic pop
);

    logic     q_wr, q_full, q_rd, q_valid;
    q_entry_t q_wdata, q_rdata;

    fhd_front #(
        .MAX_MATCH_DISTANCE (MAX_MATCH_DISTANCE)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .token  (token),
        .push   (push),
        .full   (full),
        .q_wr   (q_wr),
        .q_data (q_wdata),
        .q_full (q_full)
    );

    fhd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (q_wr),
        .wr_data  (q_wdata),
        .q_full   (q_full),
        .rd       (q_rd),
        .rd_valid (q_valid),
        .rd_data  (q_rdata)
    );

    fhd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_rdata),
        .q_rd    (q_rd),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

endmodule
